// ----- src/met_pkg.sv -----
// shared types, constants and helpers for the multi-slot event timer
package met_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int TIME_BITS   = 48;
    localparam int STEP_BITS   = 32;
    localparam int SLOT_BITS   = 3;
    localparam int NOW_BITS    = 48;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_BITS    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int REP_BITS    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_START   = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_CANCEL  = 2'd3
    } met_kind_t;

    typedef enum logic [1:0] {
        STATUS_FIRED = 2'd0,
        STATUS_OK    = 2'd1,
        STATUS_BUSY  = 2'd2
    } met_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } met_state_t;

    typedef struct packed {
        logic                capture;
        logic                time_add;
        logic                load;
        logic                cancel;
        logic                scan_upd;
        logic                use_scan;
        logic [IDX_BITS-1:0] scan_idx;
        logic                emit;
        met_status_t         emit_status;
        logic [IDX_BITS-1:0] emit_slot;
        logic                emit_last;
    } met_cmd_t;

    typedef struct packed {
        logic in_range;
        logic sel_present;
        logic sel_fire;
        logic out_free;
    } met_stat_t;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [STEP_BITS-1:0] b
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

// ----- src/met_if.sv -----
// valid/ready channel interfaces for timer commands and timer results
interface met_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [met_pkg::STEP_BITS-1:0]   delta;
    logic [met_pkg::SLOT_BITS-1:0]   slot;
    logic [met_pkg::STEP_BITS-1:0]   delay;
    logic                            one_shot;

    modport source (output valid, kind, delta, slot, delay, one_shot, input ready);
    modport sink (input valid, kind, delta, slot, delay, one_shot, output ready);
endinterface

interface met_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [met_pkg::SLOT_BITS-1:0]   fired_slot;
    logic [met_pkg::NOW_BITS-1:0]    now_time;
    logic                            last;

    modport source (output valid, status, fired_slot, now_time, last, input ready);
    modport sink (input valid, status, fired_slot, now_time, last, output ready);
endinterface

// ----- src/met_datapath.sv -----
// timer datapath: clock, slot table, due-time adder and compare, result register
module met_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  met_pkg::met_cmd_t                 cmd,
    output met_pkg::met_stat_t                stat,
    input  logic [met_pkg::STEP_BITS-1:0]     in_delta,
    input  logic [met_pkg::SLOT_BITS-1:0]     in_slot,
    input  logic [met_pkg::STEP_BITS-1:0]     in_delay,
    input  logic                              in_one_shot,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        out_status,
    output logic [met_pkg::SLOT_BITS-1:0]     out_fired_slot,
    output logic [met_pkg::NOW_BITS-1:0]      out_now_time,
    output logic                              out_last
);

    logic [met_pkg::TIME_BITS-1:0]  now_reg;
    logic [met_pkg::TIME_BITS-1:0]  due_reg      [met_pkg::NUM_SLOTS];
    logic [met_pkg::STEP_BITS-1:0]  delay_reg    [met_pkg::NUM_SLOTS];
    logic [met_pkg::NUM_SLOTS-1:0]  present_reg;
    logic [met_pkg::NUM_SLOTS-1:0]  active_reg;
    logic [met_pkg::NUM_SLOTS-1:0]  one_shot_reg;

    logic [met_pkg::STEP_BITS-1:0]  delta_reg;
    logic [met_pkg::SLOT_BITS-1:0]  slot_reg;
    logic [met_pkg::STEP_BITS-1:0]  new_delay_reg;
    logic                           new_one_shot_reg;

    logic                           out_valid_reg;
    met_pkg::met_status_t           out_status_reg;
    logic [met_pkg::SLOT_BITS-1:0]  out_slot_reg;
    logic [met_pkg::NOW_BITS-1:0]   out_now_reg;
    logic                           out_last_reg;

    logic [met_pkg::IDX_BITS-1:0]   sel;
    logic [met_pkg::TIME_BITS-1:0]  sel_due;
    logic [met_pkg::STEP_BITS-1:0]  sel_delay;
    logic                           sel_fire;
    logic                           active_after;
    logic [met_pkg::TIME_BITS-1:0]  due_next;
    logic                           out_free;

    assign sel       = cmd.use_scan ? cmd.scan_idx : met_pkg::IDX_BITS'(slot_reg);
    assign sel_due   = due_reg[sel];
    assign sel_delay = delay_reg[sel];
    assign sel_fire  = present_reg[sel] && active_reg[sel] && (now_reg >= sel_due);
    assign active_after = active_reg[sel] && !(sel_fire && one_shot_reg[sel]);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.load)
        begin
            due_next = met_pkg::sat_add(now_reg, new_delay_reg);
        end
        else
        begin
            due_next = met_pkg::sat_add(sel_due, sel_delay);
        end
    end

    assign stat.in_range    = ({29'b0, slot_reg} < 32'(met_pkg::NUM_SLOTS));
    assign stat.sel_present = present_reg[sel];
    assign stat.sel_fire    = sel_fire;
    assign stat.out_free    = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            delta_reg        <= in_delta;
            slot_reg         <= in_slot;
            new_delay_reg    <= in_delay;
            new_one_shot_reg <= in_one_shot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            present_reg  <= '0;
            active_reg   <= '0;
            one_shot_reg <= '0;
            for (int i = 0; i < met_pkg::NUM_SLOTS; i++)
            begin
                due_reg[i]   <= '0;
                delay_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.time_add)
            begin
                now_reg <= met_pkg::sat_add(now_reg, delta_reg);
            end
            if (cmd.load)
            begin
                due_reg[sel]      <= due_next;
                delay_reg[sel]    <= new_delay_reg;
                one_shot_reg[sel] <= new_one_shot_reg;
                active_reg[sel]   <= 1'b1;
                present_reg[sel]  <= 1'b1;
            end
            else if (cmd.cancel)
            begin
                active_reg[sel] <= 1'b0;
            end
            else if (cmd.scan_upd)
            begin
                if (sel_fire)
                begin
                    due_reg[sel] <= due_next;
                end
                active_reg[sel]  <= active_after;
                present_reg[sel] <= present_reg[sel] && active_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_slot_reg   <= met_pkg::SLOT_BITS'(cmd.emit_slot);
            out_now_reg    <= met_pkg::NOW_BITS'(now_reg);
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_fired_slot = out_slot_reg;
    assign out_now_time   = out_now_reg;
    assign out_last       = out_last_reg;

    a_load_cmd_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load || cmd.cancel) |-> !cmd.use_scan)
        else $error("slot command issued during scan");

    a_load_sets_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (present_reg[$past(sel)] && active_reg[$past(sel)]))
        else $error("loaded slot not present and active");

    a_active_in_present: assert property (@(posedge clk) disable iff (!rst_n)
        ((active_reg & ~present_reg) == '0))
        else $error("active slot not present");

endmodule

// ----- src/met_ctrl.sv -----
// timer controller: command sequencing, slot scan and result ordering
module met_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_kind,
    output logic                 in_ready,
    output met_pkg::met_cmd_t    cmd,
    input  met_pkg::met_stat_t   stat
);

    met_pkg::met_state_t            state_reg, state_next;
    met_pkg::met_kind_t             kind_reg, kind_next;
    logic [met_pkg::IDX_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic [met_pkg::IDX_BITS-1:0]   pend_slot_reg, pend_slot_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [met_pkg::REP_BITS-1:0]   rep_cnt_reg, rep_cnt_next;

    logic take;
    logic stall;

    assign take  = stat.sel_fire && (rep_cnt_reg < met_pkg::REP_BITS'(met_pkg::MAX_RESULTS));
    assign stall = take && pend_valid_reg && !stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= met_pkg::ST_IDLE;
            kind_reg       <= met_pkg::KIND_TICK;
            scan_idx_reg   <= '0;
            pend_slot_reg  <= '0;
            pend_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            scan_idx_reg   <= scan_idx_next;
            pend_slot_reg  <= pend_slot_next;
            pend_valid_reg <= pend_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        scan_idx_next   = scan_idx_reg;
        pend_slot_next  = pend_slot_reg;
        pend_valid_next = pend_valid_reg;
        rep_cnt_next    = rep_cnt_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.emit_status = met_pkg::STATUS_OK;
        cmd.scan_idx    = scan_idx_reg;

        case (state_reg)
            met_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    kind_next   = met_pkg::met_kind_t'(in_kind);
                    state_next  = met_pkg::ST_EXEC;
                end
            end
            met_pkg::ST_EXEC:
            begin
                if (kind_reg == met_pkg::KIND_TICK)
                begin
                    cmd.time_add    = 1'b1;
                    scan_idx_next   = '0;
                    pend_valid_next = 1'b0;
                    rep_cnt_next    = '0;
                    state_next      = met_pkg::ST_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (stat.in_range)
                    begin
                        case (kind_reg)
                            met_pkg::KIND_START:
                            begin
                                if (stat.sel_present)
                                begin
                                    cmd.emit_status = met_pkg::STATUS_BUSY;
                                end
                                else
                                begin
                                    cmd.load = 1'b1;
                                end
                            end
                            met_pkg::KIND_RESTART:
                            begin
                                cmd.load = 1'b1;
                            end
                            met_pkg::KIND_CANCEL:
                            begin
                                cmd.cancel = stat.sel_present;
                            end
                            default:
                            begin
                                cmd.load = 1'b0;
                            end
                        endcase
                    end
                    state_next = met_pkg::ST_IDLE;
                end
            end
            met_pkg::ST_SCAN:
            begin
                cmd.use_scan = 1'b1;
                if (!stall)
                begin
                    cmd.scan_upd = 1'b1;
                    if (take)
                    begin
                        if (pend_valid_reg)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = met_pkg::STATUS_FIRED;
                            cmd.emit_slot   = pend_slot_reg;
                        end
                        pend_slot_next  = scan_idx_reg;
                        pend_valid_next = 1'b1;
                        rep_cnt_next    = rep_cnt_reg + 1'b1;
                    end
                    if (scan_idx_reg == met_pkg::IDX_BITS'(met_pkg::NUM_SLOTS - 1))
                    begin
                        state_next = met_pkg::ST_DONE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            met_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        cmd.emit_status = met_pkg::STATUS_FIRED;
                        cmd.emit_slot   = pend_slot_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = met_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = met_pkg::ST_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result issued while result register occupied");

    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.time_add |=> (state_reg == met_pkg::ST_SCAN && scan_idx_reg == '0))
        else $error("tick did not start scan at first slot");

    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == met_pkg::ST_DONE && stat.out_free) |=> state_reg == met_pkg::ST_IDLE)
        else $error("scan end did not return to idle");

    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> rep_cnt_reg != '0)
        else $error("pending firing without a count");

endmodule

// ----- src/multi_slot_event_timer.sv -----
// top level of the multi-slot event timer
// A bank of met_pkg::NUM_SLOTS timer slots with one command port and one
// result port. Start, restart and cancel are captured on transfer and put
// their result in the output register in the execute state once it is free;
// a tick scans the slot table one slot per cycle through a single due-time
// comparator and saturating adder, and it yields one result per firing slot
// in slot order with last set on the final one. A new command transfer is
// taken as soon as the previous item has placed its last result in the
// output register, even if that result is still waiting to be taken; a
// stalled result port holds the scan until the register frees up.
module multi_slot_event_timer (
    input  logic          clk,
    input  logic          rst_n,
    met_in_if.sink        item,
    met_out_if.source     result
);

    met_pkg::met_cmd_t   cmd;
    met_pkg::met_stat_t  stat;

    met_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_kind  (item.kind),
        .in_ready (item.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    met_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_delta       (item.delta),
        .in_slot        (item.slot),
        .in_delay       (item.delay),
        .in_one_shot    (item.one_shot),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_status     (result.status),
        .out_fired_slot (result.fired_slot),
        .out_now_time   (result.now_time),
        .out_last       (result.last)
    );

endmodule
